### rtl/tlboa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlboa_pkg
// Types, codes and bin arithmetic for the two-level bin offset allocator.
// ----------------------------------------------------------------------------
package tlboa_pkg;

  localparam int unsigned NODES     = 1024;
  localparam int unsigned NODE_AW   = 10;
  localparam int unsigned LINK_W    = 11;
  localparam int unsigned AUX_DEPTH = NODES + 256;
  localparam int unsigned AUX_AW    = 11;

  localparam logic [LINK_W-1:0] NIL       = 11'd1024;
  localparam logic [AUX_AW-1:0] HEAD_BASE = 11'd1024;
  localparam logic [31:0]       MAX_REQUEST = 32'hF000_0000;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;
  localparam logic [1:0] REQ_REINIT = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE   = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  localparam logic [0:0] REG_TOTAL_UNITS = 1'b0;
  localparam logic [0:0] REG_EXACT_SIZE  = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] req_size;
    logic [9:0]  req_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant_offset;
    logic [9:0]  grant_handle;
    logic [31:0] grant_size;
    logic [31:0] free_total;
    logic [31:0] largest_free;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       start;
    logic [31:0]       length;
    logic [LINK_W-1:0] bnext;
    logic [LINK_W-1:0] bprev;
    logic [LINK_W-1:0] anext;
    logic [LINK_W-1:0] aprev;
    logic              in_use;
  } node_t;

  function automatic logic [4:0] high_bit32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  function automatic logic [4:0] low_bit32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  function automatic logic [2:0] high_bit8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 3'(i);
    end
    return n;
  endfunction

  function automatic logic [2:0] low_bit8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) n = 3'(i);
    end
    return n;
  endfunction

  // size -> bin, rounding down; hb is the index of the top set bit of s
  function automatic logic [7:0] bin_down(input logic [31:0] s, input logic [4:0] hb);
    logic [4:0]  sb;
    logic [31:0] sh;
    sb = hb - 5'd3;
    sh = s >> sb;
    if (s < 32'd8) return s[7:0];
    return {sb + 5'd1, sh[2:0]};
  endfunction

  // size -> bin, rounding up
  function automatic logic [7:0] bin_up(input logic [31:0] s, input logic [4:0] hb);
    logic [4:0]  sb;
    logic [31:0] sh;
    logic [31:0] low_mask;
    logic [7:0]  m;
    sb = hb - 5'd3;
    sh = s >> sb;
    low_mask = (32'd1 << sb) - 32'd1;
    m = {5'd0, sh[2:0]} + {7'd0, |(s & low_mask)};
    if (s < 32'd8) return s[7:0];
    return {sb + 5'd1, 3'd0} + m;
  endfunction

  function automatic logic [31:0] bin_size(input logic [7:0] f);
    logic [4:0] e;
    e = f[7:3];
    if (e == 5'd0) return {29'd0, f[2:0]};
    return {28'd0, 1'b1, f[2:0]} << (e - 5'd1);
  endfunction

endpackage

### rtl/two_level_bin_offset_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_bin_offset_allocator_core
// Offset range allocator: 256 float-sized bins over a node pool, with
// allocate, free with neighbor merge, report and reinit requests.
// ----------------------------------------------------------------------------
//  channel | ports                               | beat
//  --------+-------------------------------------+---------------------------
//  request | in_valid / in_ready / in_req        | one req_t per request
//  result  | out_valid / out_ready / out_rsp     | one rsp_t per request
//  config  | psel penable pwrite paddr pwdata .. | one 32-bit register write
//
//  One request at a time, run by a sequencer around a node memory (one
//  109-bit record per node) and an aux memory (spare stack + bin heads),
//  both with registered reads. Each link patch is a read-modify-write
//  of one node record.
//  Reinit and reset sweep both memories and the leaf bitmaps; no
//  request is taken during the sweep after reset.
//  A new request is taken while the previous result waits in the output
//  register; a stalled output only holds the sequencer at its last step.
module two_level_bin_offset_allocator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlboa_pkg::req_t   in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output tlboa_pkg::rsp_t   out_rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tlboa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_DONE,
    S_B0, S_B1, S_B2,
    S_A0, S_A1, S_A2, S_A3, S_A3B, S_A4, S_A5, S_A6, S_A7, S_A8, S_A9,
    S_F0, S_F1, S_F2, S_F4, S_F5, S_F6, S_F7, S_F8,
    S_RP,
    S_I0, S_I1, S_I2,
    S_R0, S_R1, S_R2, S_R3,
    S_P0, S_P1
  } state_t;

  typedef enum logic [1:0] {
    FLD_BNEXT, FLD_BPREV, FLD_ANEXT, FLD_APREV
  } fld_t;

  // memories
  node_t             node_mem [0:NODES-1];
  logic [LINK_W-1:0] aux_mem  [0:AUX_DEPTH-1];
  node_t             nm_q;
  logic [LINK_W-1:0] am_q;
  logic              nm_re, nm_we, am_re, am_we;
  logic [NODE_AW-1:0] nm_raddr, nm_waddr;
  node_t             nm_wdata;
  logic [AUX_AW-1:0] am_raddr, am_waddr;
  logic [LINK_W-1:0] am_wdata;

  // leaf bitmaps: read and write through one shared address
  logic [7:0] leaf_r [0:31];
  logic [4:0] lf_addr;
  logic [7:0] lf_rd, lf_wdata;
  logic       lf_we;

  state_t state_r, state_nxt, pt_ret_r, pt_ret_nxt, ins_ret_r, ins_ret_nxt;
  state_t rm_ret_r, rm_ret_nxt;
  fld_t   pt_fld_r, pt_fld_nxt;
  logic               boot_r, boot_nxt;
  logic [10:0]        cnt_r, cnt_nxt;
  req_t               req_r, req_nxt;
  rsp_t               res_r, res_nxt;
  rsp_t               out_rsp_r, out_rsp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        sz_r, sz_nxt;
  logic [4:0]         hb_r;
  logic [7:0]         minb_r, minb_nxt, bin_r, bin_nxt, ibin_r, ibin_nxt;
  logic [4:0]         t2_r, t2_nxt;
  logic [NODE_AW-1:0] n_r, n_nxt, nx_r, nx_nxt, oth_idx_r, oth_idx_nxt;
  logic [NODE_AW-1:0] ins_node_r, ins_node_nxt, pt_addr_r, pt_addr_nxt;
  node_t              rec_r, rec_nxt, oth_r, oth_nxt;
  logic [31:0]        rs_r, rs_nxt, st_r, st_nxt, sum_r, sum_nxt;
  logic [31:0]        ins_start_r, ins_start_nxt;
  logic [LINK_W-1:0]  ins_anext_r, ins_anext_nxt, ins_aprev_r, ins_aprev_nxt;
  logic [LINK_W-1:0]  pt_val_r, pt_val_nxt;
  logic [10:0]        sp_r, sp_nxt;
  logic [31:0]        free_sum_r, free_sum_nxt, top_r, top_nxt;
  logic [31:0]        total_r;
  logic               exact_r;

  assign lf_rd     = leaf_r[lf_addr];
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_EXACT_SIZE) ? {31'd0, exact_r} : total_r;

  always_comb begin
    logic [7:0]  bits8, nv, bin_c;
    logic [31:0] above, bs, rem;
    logic [4:0]  tt, t;
    logic [2:0]  l;
    node_t       w;

    state_nxt     = state_r;
    pt_ret_nxt    = pt_ret_r;
    ins_ret_nxt   = ins_ret_r;
    rm_ret_nxt    = rm_ret_r;
    pt_fld_nxt    = pt_fld_r;
    boot_nxt      = boot_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sz_nxt        = sz_r;
    minb_nxt      = minb_r;
    bin_nxt       = bin_r;
    ibin_nxt      = ibin_r;
    t2_nxt        = t2_r;
    n_nxt         = n_r;
    nx_nxt        = nx_r;
    oth_idx_nxt   = oth_idx_r;
    ins_node_nxt  = ins_node_r;
    pt_addr_nxt   = pt_addr_r;
    rec_nxt       = rec_r;
    oth_nxt       = oth_r;
    rs_nxt        = rs_r;
    st_nxt        = st_r;
    sum_nxt       = sum_r;
    ins_start_nxt = ins_start_r;
    ins_anext_nxt = ins_anext_r;
    ins_aprev_nxt = ins_aprev_r;
    pt_val_nxt    = pt_val_r;
    sp_nxt        = sp_r;
    free_sum_nxt  = free_sum_r;
    top_nxt       = top_r;

    nm_re = 1'b0; nm_raddr = '0;
    nm_we = 1'b0; nm_waddr = '0; nm_wdata = '0;
    am_re = 1'b0; am_raddr = '0;
    am_we = 1'b0; am_waddr = '0; am_wdata = '0;
    lf_addr = bin_r[7:3]; lf_we = 1'b0; lf_wdata = '0;

    bits8 = '0; nv = '0; bin_c = '0; above = '0; bs = '0; rem = '0;
    tt = '0; t = '0; l = '0; w = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          res_nxt = '0;
          case (in_req.req_type)
            REQ_ALLOC:  state_nxt = S_A0;
            REQ_FREE:   state_nxt = S_F0;
            REQ_REPORT: state_nxt = S_RP;
            default: begin
              state_nxt = S_B0;
              cnt_nxt   = '0;
              boot_nxt  = 1'b0;
            end
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_rsp_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // sweep: spare stack i = i, bin heads empty, in_use cleared
      S_B0: begin
        am_we    = 1'b1;
        am_waddr = cnt_r;
        am_wdata = cnt_r[10] ? NIL : cnt_r;
        if (!cnt_r[10]) begin
          nm_we    = 1'b1;
          nm_waddr = cnt_r[NODE_AW-1:0];
          nm_wdata = '0;
        end
        if (cnt_r < 11'd32) begin
          lf_addr  = cnt_r[4:0];
          lf_we    = 1'b1;
          lf_wdata = '0;
        end
        cnt_nxt = cnt_r + 11'd1;
        if (cnt_r == 11'(AUX_DEPTH - 1)) state_nxt = S_B1;
      end

      S_B1: begin
        top_nxt      = '0;
        free_sum_nxt = '0;
        sp_nxt       = '0;
        if (total_r == 32'd0) begin
          state_nxt = S_B2;
        end else begin
          sz_nxt        = total_r;
          ins_node_nxt  = '0;
          ins_start_nxt = '0;
          ins_anext_nxt = NIL;
          ins_aprev_nxt = NIL;
          ins_ret_nxt   = S_B2;
          state_nxt     = S_I0;
        end
      end

      S_B2: begin
        if (boot_r) begin
          boot_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end
      end

      // ---------------- allocate ----------------
      S_A0: begin
        if (req_r.req_size == 32'd0 || req_r.req_size > MAX_REQUEST) begin
          res_nxt.status = ST_BAD_SIZE;
          state_nxt      = S_DONE;
        end else if (sp_r[10]) begin
          res_nxt.status = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          sz_nxt    = req_r.req_size;
          state_nxt = S_A1;
        end
      end

      S_A1: state_nxt = S_A2;

      S_A2: begin
        minb_nxt  = bin_up(sz_r, hb_r);
        state_nxt = S_A3;
      end

      S_A3: begin
        t       = minb_r[7:3];
        lf_addr = t;
        bits8   = lf_rd & (8'hFF << minb_r[2:0]);
        if (top_r[t] && bits8 != 8'd0) begin
          bin_nxt   = {t, low_bit8(bits8)};
          am_re     = 1'b1;
          am_raddr  = HEAD_BASE + {3'd0, t, low_bit8(bits8)};
          state_nxt = S_A4;
        end else begin
          above = top_r & ~((32'd2 << t) - 32'd1);
          if (above == 32'd0) begin
            res_nxt.status = ST_NO_SPACE;
            state_nxt      = S_DONE;
          end else begin
            t2_nxt    = low_bit32(above);
            state_nxt = S_A3B;
          end
        end
      end

      S_A3B: begin
        lf_addr = t2_r;
        if (lf_rd == 8'd0) begin
          res_nxt.status = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          bin_nxt   = {t2_r, low_bit8(lf_rd)};
          am_re     = 1'b1;
          am_raddr  = HEAD_BASE + {3'd0, t2_r, low_bit8(lf_rd)};
          state_nxt = S_A4;
        end
      end

      S_A4: begin
        if (am_q[10]) begin
          res_nxt.status = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          n_nxt     = am_q[NODE_AW-1:0];
          nm_re     = 1'b1;
          nm_raddr  = am_q[NODE_AW-1:0];
          state_nxt = S_A5;
        end
      end

      S_A5: begin
        rec_nxt      = nm_q;
        bs           = exact_r ? req_r.req_size : bin_size(minb_r);
        rs_nxt       = (bs > nm_q.length) ? nm_q.length : bs;
        free_sum_nxt = free_sum_r - nm_q.length;
        am_we        = 1'b1;
        am_waddr     = HEAD_BASE + {3'd0, bin_r};
        am_wdata     = nm_q.bnext;
        if (nm_q.bnext[10]) begin
          // bin went empty
          lf_addr  = bin_r[7:3];
          nv       = lf_rd & ~(8'd1 << bin_r[2:0]);
          lf_we    = 1'b1;
          lf_wdata = nv;
          if (nv == 8'd0) top_nxt = top_r & ~(32'd1 << bin_r[7:3]);
          state_nxt = S_A6;
        end else begin
          pt_addr_nxt = nm_q.bnext[NODE_AW-1:0];
          pt_fld_nxt  = FLD_BPREV;
          pt_val_nxt  = NIL;
          pt_ret_nxt  = S_A6;
          state_nxt   = S_P0;
        end
      end

      S_A6: begin
        rem = rec_r.length - rs_r;
        if (rem != 32'd0) begin
          am_re     = 1'b1;
          am_raddr  = sp_r;
          state_nxt = S_A7;
        end else begin
          state_nxt = S_A9;
        end
      end

      S_A7: begin
        nx_nxt        = am_q[NODE_AW-1:0];
        sz_nxt        = rec_r.length - rs_r;
        ins_node_nxt  = am_q[NODE_AW-1:0];
        ins_start_nxt = rec_r.start + rs_r;
        ins_aprev_nxt = {1'b0, n_r};
        ins_anext_nxt = rec_r.anext;
        ins_ret_nxt   = S_A8;
        state_nxt     = S_I0;
      end

      S_A8: begin
        rec_nxt.anext = {1'b0, nx_r};
        if (!rec_r.anext[10]) begin
          pt_addr_nxt = rec_r.anext[NODE_AW-1:0];
          pt_fld_nxt  = FLD_APREV;
          pt_val_nxt  = {1'b0, nx_r};
          pt_ret_nxt  = S_A9;
          state_nxt   = S_P0;
        end else begin
          state_nxt = S_A9;
        end
      end

      S_A9: begin
        w        = rec_r;
        w.length = rs_r;
        w.in_use = 1'b1;
        nm_we    = 1'b1;
        nm_waddr = n_r;
        nm_wdata = w;
        res_nxt.status       = ST_OK;
        res_nxt.grant_offset = rec_r.start;
        res_nxt.grant_handle = n_r;
        res_nxt.grant_size   = rs_r;
        state_nxt            = S_DONE;
      end

      // ---------------- free ----------------
      S_F0: begin
        n_nxt     = req_r.req_handle;
        nm_re     = 1'b1;
        nm_raddr  = req_r.req_handle;
        state_nxt = S_F1;
      end

      S_F1: begin
        if (!nm_q.in_use) begin
          res_nxt.status = ST_BAD_HANDLE;
          state_nxt      = S_DONE;
        end else begin
          rec_nxt = nm_q;
          st_nxt  = nm_q.start;
          sum_nxt = nm_q.length;
          if (!nm_q.aprev[10]) begin
            nm_re     = 1'b1;
            nm_raddr  = nm_q.aprev[NODE_AW-1:0];
            state_nxt = S_F2;
          end else begin
            state_nxt = S_F4;
          end
        end
      end

      S_F2: begin
        if (!nm_q.in_use) begin
          st_nxt        = nm_q.start;
          sum_nxt       = sum_r + nm_q.length;
          rec_nxt.aprev = nm_q.aprev;
          oth_nxt       = nm_q;
          oth_idx_nxt   = rec_r.aprev[NODE_AW-1:0];
          rm_ret_nxt    = S_F4;
          state_nxt     = S_R0;
        end else begin
          state_nxt = S_F4;
        end
      end

      S_F4: begin
        if (!rec_r.anext[10]) begin
          nm_re     = 1'b1;
          nm_raddr  = rec_r.anext[NODE_AW-1:0];
          state_nxt = S_F5;
        end else begin
          state_nxt = S_F6;
        end
      end

      S_F5: begin
        if (!nm_q.in_use) begin
          sum_nxt       = sum_r + nm_q.length;
          rec_nxt.anext = nm_q.anext;
          oth_nxt       = nm_q;
          oth_idx_nxt   = rec_r.anext[NODE_AW-1:0];
          rm_ret_nxt    = S_F6;
          state_nxt     = S_R0;
        end else begin
          state_nxt = S_F6;
        end
      end

      S_F6: begin
        // push n; the insert below pops it straight back
        if (sp_r != 11'd0) begin
          am_we    = 1'b1;
          am_waddr = sp_r - 11'd1;
          am_wdata = {1'b0, n_r};
          sp_nxt   = sp_r - 11'd1;
        end
        sz_nxt        = sum_r;
        ins_node_nxt  = n_r;
        ins_start_nxt = st_r;
        ins_anext_nxt = rec_r.anext;
        ins_aprev_nxt = rec_r.aprev;
        ins_ret_nxt   = S_F7;
        state_nxt     = S_I0;
      end

      S_F7: begin
        if (!rec_r.anext[10]) begin
          pt_addr_nxt = rec_r.anext[NODE_AW-1:0];
          pt_fld_nxt  = FLD_APREV;
          pt_val_nxt  = {1'b0, n_r};
          pt_ret_nxt  = S_F8;
          state_nxt   = S_P0;
        end else begin
          state_nxt = S_F8;
        end
      end

      S_F8: begin
        if (!rec_r.aprev[10]) begin
          pt_addr_nxt = rec_r.aprev[NODE_AW-1:0];
          pt_fld_nxt  = FLD_ANEXT;
          pt_val_nxt  = {1'b0, n_r};
          pt_ret_nxt  = S_DONE;
          state_nxt   = S_P0;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // ---------------- report ----------------
      S_RP: begin
        if (!sp_r[10]) begin
          res_nxt.free_total = free_sum_r;
          if (top_r != 32'd0) begin
            tt      = high_bit32(top_r);
            lf_addr = tt;
            l       = (lf_rd != 8'd0) ? high_bit8(lf_rd) : 3'd0;
            res_nxt.largest_free = bin_size({tt, l});
          end
        end
        state_nxt = S_DONE;
      end

      // ---------------- insert free region ----------------
      S_I0: state_nxt = S_I1;

      S_I1: begin
        bin_c     = bin_down(sz_r, hb_r);
        ibin_nxt  = bin_c;
        am_re     = 1'b1;
        am_raddr  = HEAD_BASE + {3'd0, bin_c};
        state_nxt = S_I2;
      end

      S_I2: begin
        w.start  = ins_start_r;
        w.length = sz_r;
        w.bnext  = am_q;
        w.bprev  = NIL;
        w.anext  = ins_anext_r;
        w.aprev  = ins_aprev_r;
        w.in_use = 1'b0;
        nm_we    = 1'b1;
        nm_waddr = ins_node_r;
        nm_wdata = w;
        am_we    = 1'b1;
        am_waddr = HEAD_BASE + {3'd0, ibin_r};
        am_wdata = {1'b0, ins_node_r};
        lf_addr  = ibin_r[7:3];
        lf_we    = 1'b1;
        lf_wdata = lf_rd | (8'd1 << ibin_r[2:0]);
        top_nxt      = top_r | (32'd1 << ibin_r[7:3]);
        free_sum_nxt = free_sum_r + sz_r;
        sp_nxt       = sp_r + 11'd1;
        if (!am_q[10]) begin
          pt_addr_nxt = am_q[NODE_AW-1:0];
          pt_fld_nxt  = FLD_BPREV;
          pt_val_nxt  = {1'b0, ins_node_r};
          pt_ret_nxt  = ins_ret_r;
          state_nxt   = S_P0;
        end else begin
          state_nxt = ins_ret_r;
        end
      end

      // ---------------- unlink free region from its bin ----------------
      S_R0: begin
        free_sum_nxt = free_sum_r - oth_r.length;
        if (sp_r != 11'd0) begin
          am_we    = 1'b1;
          am_waddr = sp_r - 11'd1;
          am_wdata = {1'b0, oth_idx_r};
          sp_nxt   = sp_r - 11'd1;
        end
        if (!oth_r.bprev[10]) begin
          pt_addr_nxt = oth_r.bprev[NODE_AW-1:0];
          pt_fld_nxt  = FLD_BNEXT;
          pt_val_nxt  = oth_r.bnext;
          pt_ret_nxt  = S_R1;
          state_nxt   = S_P0;
        end else begin
          sz_nxt    = oth_r.length;
          state_nxt = S_R2;
        end
      end

      S_R1: begin
        if (!oth_r.bnext[10]) begin
          pt_addr_nxt = oth_r.bnext[NODE_AW-1:0];
          pt_fld_nxt  = FLD_BPREV;
          pt_val_nxt  = oth_r.bprev;
          pt_ret_nxt  = rm_ret_r;
          state_nxt   = S_P0;
        end else begin
          state_nxt = rm_ret_r;
        end
      end

      S_R2: state_nxt = S_R3;

      S_R3: begin
        bin_c    = bin_down(sz_r, hb_r);
        am_we    = 1'b1;
        am_waddr = HEAD_BASE + {3'd0, bin_c};
        am_wdata = oth_r.bnext;
        if (oth_r.bnext[10]) begin
          lf_addr  = bin_c[7:3];
          nv       = lf_rd & ~(8'd1 << bin_c[2:0]);
          lf_we    = 1'b1;
          lf_wdata = nv;
          if (nv == 8'd0) top_nxt = top_r & ~(32'd1 << bin_c[7:3]);
          state_nxt = rm_ret_r;
        end else begin
          pt_addr_nxt = oth_r.bnext[NODE_AW-1:0];
          pt_fld_nxt  = FLD_BPREV;
          pt_val_nxt  = NIL;
          pt_ret_nxt  = rm_ret_r;
          state_nxt   = S_P0;
        end
      end

      // ---------------- single-link read-modify-write ----------------
      S_P0: begin
        nm_re     = 1'b1;
        nm_raddr  = pt_addr_r;
        state_nxt = S_P1;
      end

      S_P1: begin
        w = nm_q;
        case (pt_fld_r)
          FLD_BNEXT: w.bnext = pt_val_r;
          FLD_BPREV: w.bprev = pt_val_r;
          FLD_ANEXT: w.anext = pt_val_r;
          default:   w.aprev = pt_val_r;
        endcase
        nm_we     = 1'b1;
        nm_waddr  = pt_addr_r;
        nm_wdata  = w;
        state_nxt = pt_ret_r;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_B0;
      boot_r      <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
      top_r       <= '0;
      free_sum_r  <= '0;
      pt_ret_r    <= S_IDLE;
      ins_ret_r   <= S_IDLE;
      rm_ret_r    <= S_IDLE;
      pt_fld_r    <= FLD_BNEXT;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sp_r        <= sp_nxt;
      top_r       <= top_nxt;
      free_sum_r  <= free_sum_nxt;
      pt_ret_r    <= pt_ret_nxt;
      ins_ret_r   <= ins_ret_nxt;
      rm_ret_r    <= rm_ret_nxt;
      pt_fld_r    <= pt_fld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    out_rsp_r   <= out_rsp_nxt;
    sz_r        <= sz_nxt;
    hb_r        <= high_bit32(sz_r);
    minb_r      <= minb_nxt;
    bin_r       <= bin_nxt;
    ibin_r      <= ibin_nxt;
    t2_r        <= t2_nxt;
    n_r         <= n_nxt;
    nx_r        <= nx_nxt;
    oth_idx_r   <= oth_idx_nxt;
    ins_node_r  <= ins_node_nxt;
    pt_addr_r   <= pt_addr_nxt;
    rec_r       <= rec_nxt;
    oth_r       <= oth_nxt;
    rs_r        <= rs_nxt;
    st_r        <= st_nxt;
    sum_r       <= sum_nxt;
    ins_start_r <= ins_start_nxt;
    ins_anext_r <= ins_anext_nxt;
    ins_aprev_r <= ins_aprev_nxt;
    pt_val_r    <= pt_val_nxt;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= MAX_REQUEST;
      exact_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_TOTAL_UNITS) total_r <= pwdata;
      else exact_r <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (lf_we) leaf_r[lf_addr] <= lf_wdata;
  end

  always_ff @(posedge clk) begin
    if (nm_we) node_mem[nm_waddr] <= nm_wdata;
    if (nm_re) nm_q <= node_mem[nm_raddr];
  end

  always_ff @(posedge clk) begin
    if (am_we) aux_mem[am_waddr] <= am_wdata;
    if (am_re) am_q <= aux_mem[am_raddr];
  end

endmodule
